FILE: src/bnms_pkg.sv
// ============================================================================
// bnms_pkg
// Shared types and constants of the box non-maximum suppression block.
// ============================================================================
package bnms_pkg;

    // Configuration register indexes.
    localparam logic CFG_IOU_THRESHOLD = 1'b0;
    localparam logic CFG_MAX_KEEP      = 1'b1;

    localparam int CFG_IDX_W  = 1;
    localparam int THR_W      = 17;
    localparam int KEEP_W     = 7;
    localparam int SCORE_W    = 16;
    localparam int IDX_OUT_W  = 6;
    localparam int SET_CNT_W  = 7;
    localparam int CFG_DATA_W = 17;

    localparam logic [THR_W-1:0]  THR_RESET  = 17'd29491;
    localparam logic [KEEP_W-1:0] KEEP_RESET = 7'd0;

    // One pixel in Q12.4, added for the inclusive edge rule.
    localparam int ONE_PIXEL = 16;

    // A loaded set handed from the loader to the suppression engine.
    typedef struct packed {
        logic [SET_CNT_W-1:0] count;
    } t_set_cmd;

    // Engine status seen by the loader.
    typedef struct packed {
        logic busy;
        logic done;
    } t_back_stat;

endpackage

FILE: src/bnms_ram.sv
// ============================================================================
// bnms_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ============================================================================
module bnms_ram #(
    parameter int WIDTH = 80,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: src/bnms_cmdq.sv
// ============================================================================
// bnms_cmdq
// Two-entry queue of loaded-set commands between loader and engine.
// ============================================================================
module bnms_cmdq (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  bnms_pkg::t_set_cmd i_cmd,
    output logic              o_full,
    input  logic              i_pop,
    output logic              o_valid,
    output bnms_pkg::t_set_cmd o_cmd
);

    bnms_pkg::t_set_cmd r_slot [2];
    logic               r_wptr;
    logic               r_rptr;
    logic [1:0]         r_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= 1'b0;
            r_rptr  <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (i_push && !o_full) begin
                r_slot[r_wptr] <= i_cmd;
                r_wptr         <= ~r_wptr;
            end
            if (i_pop && o_valid) begin
                r_rptr <= ~r_rptr;
            end
            r_count <= r_count + 2'(i_push && !o_full) - 2'(i_pop && o_valid);
        end
    end

    assign o_full  = (r_count == 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign o_cmd   = r_slot[r_rptr];

endmodule

FILE: src/bnms_front.sv
// ============================================================================
// bnms_front
// Loader: accepts boxes, writes them to the box store, and hands off a set.
// ============================================================================
module bnms_front #(
    parameter int MAX_BOXES   = 64,
    parameter int COORD_WIDTH = 16
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_in_valid,
    output logic                                   o_in_stall,
    input  logic [4*COORD_WIDTH+bnms_pkg::SCORE_W-1:0] i_word,
    input  logic                                   i_final,
    output logic                                   o_we,
    output logic [$clog2(MAX_BOXES)-1:0]           o_waddr,
    output logic [4*COORD_WIDTH+bnms_pkg::SCORE_W-1:0] o_wdata,
    output logic                                   o_push,
    output bnms_pkg::t_set_cmd                     o_cmd,
    input  logic                                   i_q_full,
    input  bnms_pkg::t_back_stat                   i_stat
);

    localparam int IW = $clog2(MAX_BOXES);
    localparam int CNW = bnms_pkg::SET_CNT_W;

    logic [CNW-1:0] r_loaded;
    logic           r_hold;
    logic           accept;
    logic           room;

    assign accept = i_in_valid && !o_in_stall;
    assign room   = (r_loaded < CNW'(MAX_BOXES));

    // A box beyond the store capacity is dropped, but a final flag still closes the set.
    assign o_we         = accept && room;
    assign o_waddr      = r_loaded[IW-1:0];
    assign o_wdata      = i_word;
    assign o_push       = accept && i_final;
    assign o_cmd.count  = r_loaded + CNW'(room);
    assign o_in_stall   = r_hold || i_q_full || i_stat.busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_loaded <= '0;
            r_hold   <= 1'b0;
        end else begin
            if (accept) begin
                if (i_final) begin
                    r_loaded <= '0;
                    r_hold   <= 1'b1;
                end else if (room) begin
                    r_loaded <= r_loaded + CNW'(1);
                end
            end
            if (i_stat.done) begin
                r_hold <= 1'b0;
            end
        end
    end

endmodule

FILE: src/bnms_back.sv
// ============================================================================
// bnms_back
// Suppression engine: repeated passes over the store pick the next best box
// and remove boxes that overlap the current kept box too much.
// ============================================================================
module bnms_back #(
    parameter int MAX_BOXES   = 64,
    parameter int COORD_WIDTH = 16
) (
    input  logic                                     i_clk,
    input  logic                                     i_rst_n,
    input  logic [bnms_pkg::THR_W-1:0]               i_thr,
    input  logic [bnms_pkg::KEEP_W-1:0]              i_max_keep,
    input  logic                                     i_cmd_valid,
    input  bnms_pkg::t_set_cmd                       i_cmd,
    output logic                                     o_cmd_pop,
    output logic [$clog2(MAX_BOXES)-1:0]             o_raddr,
    input  logic [4*COORD_WIDTH+bnms_pkg::SCORE_W-1:0] i_rdata,
    output bnms_pkg::t_back_stat                     o_stat,
    output logic                                     o_out_valid,
    input  logic                                     i_out_stall,
    output logic [4*COORD_WIDTH+bnms_pkg::SCORE_W-1:0] o_out_word,
    output logic [bnms_pkg::IDX_OUT_W-1:0]           o_out_index,
    output logic                                     o_out_final
);

    localparam int CW  = COORD_WIDTH;
    localparam int IW  = $clog2(MAX_BOXES);
    localparam int WW  = 4*CW + bnms_pkg::SCORE_W;
    localparam int SW  = CW + 1;
    localparam int AW  = 2*SW;
    localparam int UW  = AW + 1;
    localparam int HW  = (UW + 1) / 2;
    localparam int TW  = bnms_pkg::THR_W;
    localparam int RW  = TW + UW;
    localparam int CNW = bnms_pkg::SET_CNT_W;
    localparam int SCORE_W_T = bnms_pkg::SCORE_W;

    typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_DECIDE, ST_EMIT} t_state;

    function automatic logic [SW-1:0] side_len(logic signed [CW-1:0] lo,
                                               logic signed [CW-1:0] hi);
        logic signed [CW+1:0] d;
        d = (CW+2)'(hi) - (CW+2)'(lo) + (CW+2)'(bnms_pkg::ONE_PIXEL);
        return (d > 0) ? d[SW-1:0] : '0;
    endfunction

    t_state          r_state;
    logic [CNW-1:0]  r_n;
    logic [CNW-1:0]  r_addr;
    logic [CNW-1:0]  r_kept;
    logic [MAX_BOXES-1:0] r_done;
    logic            r_have_cur;
    logic [IW-1:0]   r_cur_i;
    logic [WW-1:0]   r_cur_w;
    logic [AW-1:0]   r_cur_a;
    logic            r_best_v;
    logic [IW-1:0]   r_best_i;
    logic [WW-1:0]   r_best_w;
    logic [AW-1:0]   r_best_a;
    logic            r_fin;
    logic            r_adopt;
    logic            r_set_done;
    logic            r_ovalid;
    logic [WW-1:0]   r_out_w;
    logic [IW-1:0]   r_out_i;
    logic            r_out_fin;

    // Pass pipeline: read, sides, products, union and partial products, compare.
    logic            r_v1, r_v2, r_v3, r_v4;
    logic [IW-1:0]   r_i1, r_i2, r_i3, r_i4;
    logic [WW-1:0]   r_w2, r_w3, r_w4;
    logic [SW-1:0]   r_iw, r_ih, r_ow, r_oh;
    logic [AW-1:0]   r_inter3, r_oa3, r_inter4, r_oa4;
    logic [UW-1:0]   r_un4;
    logic [TW+HW-1:0]      r_plo;
    logic [TW+UW-HW-1:0]   r_phi;

    logic signed [CW-1:0] ol, ot, orr, ob, cl, ct, cr, cb;
    logic signed [CW-1:0] il, it, ir, ib;
    logic [UW-1:0]   un3;
    logic [RW-1:0]   lhs, rhs;
    logic            over;
    logic [SCORE_W_T-1:0] score4;
    logic            issue;
    logic            pipe_empty;
    logic            lim_hit;

    assign ol  = i_rdata[CW-1:0];
    assign ot  = i_rdata[2*CW-1:CW];
    assign orr = i_rdata[3*CW-1:2*CW];
    assign ob  = i_rdata[4*CW-1:3*CW];
    assign cl  = r_cur_w[CW-1:0];
    assign ct  = r_cur_w[2*CW-1:CW];
    assign cr  = r_cur_w[3*CW-1:2*CW];
    assign cb  = r_cur_w[4*CW-1:3*CW];
    assign il  = (ol > cl) ? ol : cl;
    assign it  = (ot > ct) ? ot : ct;
    assign ir  = (orr < cr) ? orr : cr;
    assign ib  = (ob < cb) ? ob : cb;

    assign un3    = UW'(r_cur_a) + UW'(r_oa3) - UW'(r_inter3);
    assign lhs    = RW'(r_inter4) << 16;
    assign rhs    = (RW'(r_phi) << HW) + RW'(r_plo);
    assign over   = r_have_cur && (r_un4 != '0) && (lhs > rhs);
    assign score4 = r_w4[WW-1 -: SCORE_W_T];

    assign issue      = (r_state == ST_SCAN) && (r_addr < r_n);
    assign pipe_empty = !(r_v1 || r_v2 || r_v3 || r_v4);
    assign lim_hit    = (i_max_keep != '0) &&
                        ({1'b0, i_max_keep} <= (8'(r_kept) + 8'd1));

    assign o_raddr   = r_addr[IW-1:0];
    assign o_cmd_pop = (r_state == ST_IDLE) && i_cmd_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            r_v1 <= issue;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
        end
        r_i1 <= r_addr[IW-1:0];
        r_i2 <= r_i1;
        r_w2 <= i_rdata;
        r_iw <= side_len(il, ir);
        r_ih <= side_len(it, ib);
        r_ow <= side_len(ol, orr);
        r_oh <= side_len(ot, ob);
        r_i3 <= r_i2;
        r_w3 <= r_w2;
        r_inter3 <= r_iw * r_ih;
        r_oa3    <= r_ow * r_oh;
        r_i4 <= r_i3;
        r_w4 <= r_w3;
        r_inter4 <= r_inter3;
        r_oa4    <= r_oa3;
        r_un4    <= un3;
        r_plo    <= i_thr * un3[HW-1:0];
        r_phi    <= i_thr * un3[UW-1:HW];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_done     <= '0;
            r_have_cur <= 1'b0;
            r_best_v   <= 1'b0;
            r_ovalid   <= 1'b0;
            r_set_done <= 1'b0;
            r_addr     <= '0;
            r_kept     <= '0;
            r_n        <= '0;
            r_fin      <= 1'b0;
            r_adopt    <= 1'b0;
        end else begin
            // The set is finished when the last result is loaded into the output register.
            r_set_done <= (r_state == ST_EMIT) && (!r_ovalid || !i_out_stall) && !r_adopt;
            if (r_ovalid && !i_out_stall && (r_state != ST_EMIT)) begin
                r_ovalid <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (i_cmd_valid) begin
                        r_n        <= i_cmd.count;
                        r_done     <= '0;
                        r_have_cur <= 1'b0;
                        r_kept     <= '0;
                        r_addr     <= '0;
                        r_best_v   <= 1'b0;
                        r_state    <= ST_SCAN;
                    end
                end
                ST_SCAN: begin
                    if (issue) begin
                        r_addr <= r_addr + CNW'(1);
                    end
                    if (r_v4 && !r_done[r_i4]) begin
                        if (over) begin
                            r_done[r_i4] <= 1'b1;
                        end else if (!r_best_v || score4 > r_best_w[WW-1 -: SCORE_W_T]) begin
                            // Strict compare: equal scores keep the earlier arrival.
                            r_best_v <= 1'b1;
                            r_best_i <= r_i4;
                            r_best_w <= r_w4;
                            r_best_a <= r_oa4;
                        end
                    end
                    if (!issue && pipe_empty) begin
                        r_state <= ST_DECIDE;
                    end
                end
                ST_DECIDE: begin
                    if (r_best_v && r_have_cur) begin
                        r_fin   <= 1'b0;
                        r_adopt <= 1'b1;
                        r_state <= ST_EMIT;
                    end else if (r_best_v) begin
                        r_cur_i          <= r_best_i;
                        r_cur_w          <= r_best_w;
                        r_cur_a          <= r_best_a;
                        r_done[r_best_i] <= 1'b1;
                        r_have_cur       <= 1'b1;
                        r_kept           <= r_kept + CNW'(1);
                        if (lim_hit) begin
                            r_fin   <= 1'b1;
                            r_adopt <= 1'b0;
                            r_state <= ST_EMIT;
                        end else begin
                            r_addr   <= '0;
                            r_best_v <= 1'b0;
                            r_state  <= ST_SCAN;
                        end
                    end else begin
                        r_fin   <= 1'b1;
                        r_adopt <= 1'b0;
                        r_state <= ST_EMIT;
                    end
                end
                ST_EMIT: begin
                    if (!r_ovalid || !i_out_stall) begin
                        r_ovalid  <= 1'b1;
                        r_out_w   <= r_cur_w;
                        r_out_i   <= r_cur_i;
                        r_out_fin <= r_fin;
                        if (r_adopt) begin
                            r_cur_i          <= r_best_i;
                            r_cur_w          <= r_best_w;
                            r_cur_a          <= r_best_a;
                            r_done[r_best_i] <= 1'b1;
                            r_kept           <= r_kept + CNW'(1);
                            if (lim_hit) begin
                                r_fin   <= 1'b1;
                                r_adopt <= 1'b0;
                            end else begin
                                r_addr   <= '0;
                                r_best_v <= 1'b0;
                                r_state  <= ST_SCAN;
                            end
                        end else begin
                            r_state <= ST_IDLE;
                        end
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign o_stat.busy = (r_state != ST_IDLE);
    assign o_stat.done = r_set_done;
    assign o_out_valid = r_ovalid;
    assign o_out_word  = r_out_w;
    assign o_out_index = bnms_pkg::IDX_OUT_W'(r_out_i);
    assign o_out_final = r_out_fin;

endmodule

FILE: src/box_non_maximum_suppression.sv
// ============================================================================
// box_non_maximum_suppression
// Greedy IoU-based non-maximum suppression over one set of detection boxes.
// ============================================================================
// Boxes arrive on the input channel (i_in_valid / o_in_stall), one request
// per box, and are stored in arrival order. The request with i_final_box set
// closes the set; boxes beyond MAX_BOXES are dropped, but a final flag still
// closes the set. Loading takes one box per cycle unless the input stalls.
// After the final box the input stalls while the engine works. Each pass
// reads the whole stored set once through a five-stage pipeline, removing
// boxes that overlap the current kept box too much and picking the next
// best survivor. A set with k kept boxes takes about k + 1 passes plus
// output waits; the single box-store read port bounds each pass.
// Kept boxes leave on the output channel (o_out_valid / i_out_stall) in
// descending score order, equal scores in arrival order, the last one
// flagged with o_final_kept. A stalled result holds in the output register.
// Configuration (threshold, max_keep) is written through i_cfg_we while
// idle; the user must keep to this, as the block itself does not enforce it.
// Reset is synchronous and active low; it drops any loaded set and restores
// the threshold to 29491 (about 0.45) and max_keep to zero (no limit).
// ============================================================================
module box_non_maximum_suppression #(
    parameter int MAX_BOXES   = 64,
    parameter int COORD_WIDTH = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [bnms_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [bnms_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic signed [COORD_WIDTH-1:0]     i_left_x,
    input  logic signed [COORD_WIDTH-1:0]     i_top_y,
    input  logic signed [COORD_WIDTH-1:0]     i_right_x,
    input  logic signed [COORD_WIDTH-1:0]     i_bottom_y,
    input  logic [bnms_pkg::SCORE_W-1:0]      i_confidence,
    input  logic                              i_final_box,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic signed [COORD_WIDTH-1:0]     o_kept_left_x,
    output logic signed [COORD_WIDTH-1:0]     o_kept_top_y,
    output logic signed [COORD_WIDTH-1:0]     o_kept_right_x,
    output logic signed [COORD_WIDTH-1:0]     o_kept_bottom_y,
    output logic [bnms_pkg::SCORE_W-1:0]      o_kept_confidence,
    output logic [bnms_pkg::IDX_OUT_W-1:0]    o_arrival_index,
    output logic                              o_final_kept
);

    localparam int CW = COORD_WIDTH;
    localparam int IW = $clog2(MAX_BOXES);
    localparam int WW = 4*CW + bnms_pkg::SCORE_W;

    // Configuration registers.
    logic [bnms_pkg::THR_W-1:0]  r_iou_thr;
    logic [bnms_pkg::KEEP_W-1:0] r_max_keep;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_iou_thr  <= bnms_pkg::THR_RESET;
            r_max_keep <= bnms_pkg::KEEP_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                bnms_pkg::CFG_IOU_THRESHOLD: r_iou_thr  <= i_cfg_data;
                bnms_pkg::CFG_MAX_KEEP:      r_max_keep <= i_cfg_data[bnms_pkg::KEEP_W-1:0];
                default: ;
            endcase
        end
    end

    logic                  ram_we;
    logic [IW-1:0]         ram_waddr;
    logic [WW-1:0]         ram_wdata;
    logic [IW-1:0]         ram_raddr;
    logic [WW-1:0]         ram_rdata;
    logic                  q_push;
    logic                  q_full;
    logic                  q_pop;
    logic                  q_valid;
    bnms_pkg::t_set_cmd    q_in;
    bnms_pkg::t_set_cmd    q_out;
    bnms_pkg::t_back_stat  stat;
    logic [WW-1:0]         in_word;
    logic [WW-1:0]         out_word;

    // Stored word: score on top, then bottom, right, top and left edges.
    assign in_word = {i_confidence, i_bottom_y, i_right_x, i_top_y, i_left_x};

    bnms_front #(
        .MAX_BOXES  (MAX_BOXES),
        .COORD_WIDTH(COORD_WIDTH)
    ) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in_valid(i_in_valid),
        .o_in_stall(o_in_stall),
        .i_word    (in_word),
        .i_final   (i_final_box),
        .o_we      (ram_we),
        .o_waddr   (ram_waddr),
        .o_wdata   (ram_wdata),
        .o_push    (q_push),
        .o_cmd     (q_in),
        .i_q_full  (q_full),
        .i_stat    (stat)
    );

    bnms_ram #(
        .WIDTH(WW),
        .DEPTH(MAX_BOXES)
    ) u_store (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ram_waddr),
        .i_wdata(ram_wdata),
        .i_raddr(ram_raddr),
        .o_rdata(ram_rdata)
    );

    bnms_cmdq u_cmdq (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (q_push),
        .i_cmd  (q_in),
        .o_full (q_full),
        .i_pop  (q_pop),
        .o_valid(q_valid),
        .o_cmd  (q_out)
    );

    bnms_back #(
        .MAX_BOXES  (MAX_BOXES),
        .COORD_WIDTH(COORD_WIDTH)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_thr      (r_iou_thr),
        .i_max_keep (r_max_keep),
        .i_cmd_valid(q_valid),
        .i_cmd      (q_out),
        .o_cmd_pop  (q_pop),
        .o_raddr    (ram_raddr),
        .i_rdata    (ram_rdata),
        .o_stat     (stat),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_out_word (out_word),
        .o_out_index(o_arrival_index),
        .o_out_final(o_final_kept)
    );

    assign o_kept_left_x     = out_word[CW-1:0];
    assign o_kept_top_y      = out_word[2*CW-1:CW];
    assign o_kept_right_x    = out_word[3*CW-1:2*CW];
    assign o_kept_bottom_y   = out_word[4*CW-1:3*CW];
    assign o_kept_confidence = out_word[WW-1 -: bnms_pkg::SCORE_W];

    // While the engine owns the store, no new box may be taken.
    a_busy_stalls: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        stat.busy |-> o_in_stall)
        else $error("input not stalled while engine busy");

    // The store is never written while the engine reads it.
    a_no_write_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_we |-> !stat.busy)
        else $error("store written during suppression");

    // A set completes only out of a busy engine.
    a_done_from_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        stat.done |-> $past(stat.busy))
        else $error("set done without work");

endmodule

FILE: bench/nms_checker.sv
// ============================================================================
// nms_checker
// Watches the box, result and register ports of the suppression block.
// ============================================================================
// Accepted boxes, up to MAX_BOXES, go into a local set. When the final box
// of a set is accepted, the surviving boxes are worked out here and queued.
// Each accepted result is compared field by field with the oldest queued box.
// The failure count and the number of boxes still owed go to the bench top.
// ============================================================================
module nms_checker #(
    parameter int MAX_BOXES   = 64,
    parameter int COORD_WIDTH = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [bnms_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [bnms_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  logic                              i_in_valid,
    input  logic                              i_in_stall,
    input  logic signed [COORD_WIDTH-1:0]     i_left_x,
    input  logic signed [COORD_WIDTH-1:0]     i_top_y,
    input  logic signed [COORD_WIDTH-1:0]     i_right_x,
    input  logic signed [COORD_WIDTH-1:0]     i_bottom_y,
    input  logic [bnms_pkg::SCORE_W-1:0]      i_confidence,
    input  logic                              i_final_box,
    input  logic                              i_out_valid,
    input  logic                              i_out_stall,
    input  logic signed [COORD_WIDTH-1:0]     i_kept_left_x,
    input  logic signed [COORD_WIDTH-1:0]     i_kept_top_y,
    input  logic signed [COORD_WIDTH-1:0]     i_kept_right_x,
    input  logic signed [COORD_WIDTH-1:0]     i_kept_bottom_y,
    input  logic [bnms_pkg::SCORE_W-1:0]      i_kept_confidence,
    input  logic [bnms_pkg::IDX_OUT_W-1:0]    i_arrival_index,
    input  logic                              i_final_kept,
    output int                                o_fail_count,
    output int                                o_owed_count
);

    typedef struct packed {
        logic signed [COORD_WIDTH-1:0]     lx;
        logic signed [COORD_WIDTH-1:0]     ty;
        logic signed [COORD_WIDTH-1:0]     rx;
        logic signed [COORD_WIDTH-1:0]     by;
        logic [bnms_pkg::SCORE_W-1:0]      score;
        logic [bnms_pkg::IDX_OUT_W-1:0]    idx;
        logic                              last;
    } t_kept_box;

    t_kept_box                      set_boxes[MAX_BOXES];
    int                             set_count;
    t_kept_box                      kept_boxes_q[$];
    logic [bnms_pkg::THR_W-1:0]     iou_thr;
    logic [bnms_pkg::KEEP_W-1:0]    keep_limit;

    function automatic longint unsigned side_len(longint lo, longint hi);
        longint d;
        d = hi - lo + bnms_pkg::ONE_PIXEL;
        return (d > 0) ? longint'(d) : 0;
    endfunction

    function automatic longint unsigned area_of(longint l, longint t, longint r, longint b);
        return side_len(l, r) * side_len(t, b);
    endfunction

    // Exact integer IoU test: inter * 2^16 > threshold * union.
    function automatic bit overlaps_too_much(t_kept_box a, t_kept_box b);
        longint unsigned inter, uni;
        longint il, it, ir, ib;
        il = (a.lx > b.lx) ? a.lx : b.lx;
        it = (a.ty > b.ty) ? a.ty : b.ty;
        ir = (a.rx < b.rx) ? a.rx : b.rx;
        ib = (a.by < b.by) ? a.by : b.by;
        inter = area_of(il, it, ir, ib);
        uni = area_of(a.lx, a.ty, a.rx, a.by) + area_of(b.lx, b.ty, b.rx, b.by) - inter;
        if (uni == 0) return 1'b0;
        return (inter << 16) > (longint'(iou_thr) * uni);
    endfunction

    task automatic predict_survivors();
        int order[MAX_BOXES];
        bit removed[MAX_BOXES];
        int i, j, cur, kept;
        for (i = 0; i < set_count; i++) begin
            j = i;
            while (j > 0 && set_boxes[order[j-1]].score < set_boxes[i].score) begin
                order[j] = order[j-1];
                j--;
            end
            order[j] = i;
            removed[i] = 1'b0;
        end
        kept = 0;
        for (i = 0; i < set_count; i++) begin
            cur = order[i];
            if (removed[cur]) continue;
            kept_boxes_q = {kept_boxes_q, set_boxes[cur]};
            kept++;
            for (j = i + 1; j < set_count; j++)
                if (!removed[order[j]] && overlaps_too_much(set_boxes[cur], set_boxes[order[j]]))
                    removed[order[j]] = 1'b1;
            if (keep_limit != 0 && kept >= keep_limit) break;
        end
        if (kept > 0) kept_boxes_q[kept_boxes_q.size()-1].last = 1'b1;
    endtask

    always @(posedge i_clk) begin
        t_kept_box got, want;
        if (!i_rst_n) begin
            set_count = 0;
            iou_thr <= bnms_pkg::THR_RESET;
            keep_limit <= bnms_pkg::KEEP_RESET;
            o_fail_count <= 0;
            o_owed_count <= 0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_index == bnms_pkg::CFG_IOU_THRESHOLD)
                    iou_thr <= i_cfg_data[bnms_pkg::THR_W-1:0];
                else
                    keep_limit <= i_cfg_data[bnms_pkg::KEEP_W-1:0];
            end
            if (i_in_valid && !i_in_stall) begin
                if (set_count < MAX_BOXES) begin
                    set_boxes[set_count] = '{i_left_x, i_top_y, i_right_x, i_bottom_y,
                                             i_confidence,
                                             bnms_pkg::IDX_OUT_W'(set_count), 1'b0};
                    set_count = set_count + 1;
                end
                if (i_final_box) begin
                    predict_survivors();
                    set_count = 0;
                end
            end
            if (i_out_valid && !i_out_stall) begin
                got = '{i_kept_left_x, i_kept_top_y, i_kept_right_x, i_kept_bottom_y,
                        i_kept_confidence, i_arrival_index, i_final_kept};
                if (kept_boxes_q.size() == 0) begin
                    if (o_fail_count < 10)
                        $display("unexpected result: %p", got);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    want = kept_boxes_q.pop_front();
                    if (got !== want) begin
                        if (o_fail_count < 10)
                            $display("mismatch: expected %p, got %p", want, got);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
            o_owed_count <= kept_boxes_q.size();
        end
    end

endmodule

FILE: bench/testbench.sv
// ============================================================================
// testbench
// Stimulus and verdict for the box non-maximum suppression block.
// ============================================================================
// Sends directed sets of boxes (extreme corners, zero-area boxes, tied scores,
// threshold and keep-limit extremes) and then random sets, mostly clustered
// boxes so that suppression really happens, under several register settings.
// Both channels idle in random bursts except in the closing stretch. The
// checker instance predicts and compares; this module only drives and judges.
// ============================================================================
module testbench;

    localparam int CW = 16;
    // Longest idle stretch allowed: a full set takes tens of passes plus
    // output stalls.
    localparam int WATCHDOG_LIMIT = 40000;
    // Settle time after the last result before touching the registers.
    localparam int SETTLE_CYCLES = 300;

    logic                             i_clk = 1'b0;
    logic                             i_rst_n = 1'b0;
    logic                             i_cfg_we = 1'b0;
    logic [bnms_pkg::CFG_IDX_W-1:0]   i_cfg_index = bnms_pkg::CFG_IOU_THRESHOLD;
    logic [bnms_pkg::CFG_DATA_W-1:0]  i_cfg_data = '0;
    logic                             i_in_valid = 1'b0;
    logic                             o_in_stall;
    logic signed [CW-1:0]   i_left_x = '0, i_top_y = '0, i_right_x = '0, i_bottom_y = '0;
    logic [bnms_pkg::SCORE_W-1:0]     i_confidence = '0;
    logic                             i_final_box = 1'b0;
    logic                             o_out_valid;
    logic                             i_out_stall = 1'b0;
    logic signed [CW-1:0]   o_kept_left_x, o_kept_top_y, o_kept_right_x, o_kept_bottom_y;
    logic [bnms_pkg::SCORE_W-1:0]     o_kept_confidence;
    logic [bnms_pkg::IDX_OUT_W-1:0]   o_arrival_index;
    logic                             o_final_kept;
    int                               fail_count, owed_count;

    // When set, neither side idles any more.
    bit quiet = 1'b0;
    int boxes_sent = 0;
    int idle_cycles = 0;
    int stall_left = 0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    box_non_maximum_suppression #(.MAX_BOXES(64), .COORD_WIDTH(CW)) dut (.*);

    nms_checker #(.MAX_BOXES(64), .COORD_WIDTH(CW)) u_checker (
        .i_clk, .i_rst_n, .i_cfg_we, .i_cfg_index, .i_cfg_data,
        .i_in_valid, .i_in_stall(o_in_stall),
        .i_left_x, .i_top_y, .i_right_x, .i_bottom_y, .i_confidence, .i_final_box,
        .i_out_valid(o_out_valid), .i_out_stall,
        .i_kept_left_x(o_kept_left_x), .i_kept_top_y(o_kept_top_y),
        .i_kept_right_x(o_kept_right_x), .i_kept_bottom_y(o_kept_bottom_y),
        .i_kept_confidence(o_kept_confidence), .i_arrival_index(o_arrival_index),
        .i_final_kept(o_final_kept),
        .o_fail_count(fail_count), .o_owed_count(owed_count)
    );

    // The result side stalls in bursts of random length; the burst start is
    // rare enough that long unstalled stretches also occur.
    always @(posedge i_clk) begin
        if (!i_rst_n || quiet) begin
            i_out_stall <= 1'b0;
            stall_left <= 0;
        end else if (stall_left > 0) begin
            i_out_stall <= 1'b1;
            stall_left <= stall_left - 1;
        end else if ($urandom_range(0, 5) == 0) begin
            i_out_stall <= 1'b1;
            stall_left <= $urandom_range(0, 10);
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    // Watchdog: any accepted request or register write clears the count.
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) || i_cfg_we)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // One box request. An optional gap is taken first with valid low, then the
    // request is held until an edge at which the stall seen mid-cycle was low.
    task automatic send_box(int lx, int ty, int rx, int by, int score, bit last);
        bit stalled;
        if (!quiet && $urandom_range(0, 3) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge i_clk);
        end
        i_left_x <= CW'(lx);
        i_top_y <= CW'(ty);
        i_right_x <= CW'(rx);
        i_bottom_y <= CW'(by);
        i_confidence <= bnms_pkg::SCORE_W'(score);
        i_final_box <= last;
        i_in_valid <= 1'b1;
        do begin
            @(negedge i_clk);
            stalled = o_in_stall;
            @(posedge i_clk);
        end while (stalled);
        boxes_sent++;
    endtask

    // Registers are only written with the block idle: no result owed and the
    // engine given time to finish its last pass.
    task automatic drain_and_configure(int thr, int keep);
        i_in_valid <= 1'b0;
        repeat (2) @(posedge i_clk);
        while (owed_count != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= bnms_pkg::CFG_IOU_THRESHOLD;
        i_cfg_data <= bnms_pkg::CFG_DATA_W'(thr);
        @(posedge i_clk);
        i_cfg_index <= bnms_pkg::CFG_MAX_KEEP;
        i_cfg_data <= bnms_pkg::CFG_DATA_W'(keep);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // A random set: mostly boxes jittered around a few cluster centers, some
    // spread over the whole coordinate range, some with inverted corners.
    task automatic send_random_set(int count);
        int cx[3], cy[3];
        int k, c, w, h, lx, ty, score, kind;
        for (k = 0; k < 3; k++) begin
            cx[k] = $urandom_range(0, 6000) - 3000;
            cy[k] = $urandom_range(0, 6000) - 3000;
        end
        for (k = 0; k < count; k++) begin
            kind = $urandom_range(0, 9);
            score = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 3) * 21845
                                                : $urandom_range(0, 65535);
            if (kind < 7) begin
                c = $urandom_range(0, 2);
                w = $urandom_range(16, 800);
                h = $urandom_range(16, 800);
                lx = cx[c] + $urandom_range(0, 64) - 32;
                ty = cy[c] + $urandom_range(0, 64) - 32;
                send_box(lx, ty, lx + w, ty + h, score, k == count - 1);
            end else if (kind < 9) begin
                send_box($urandom, $urandom, $urandom, $urandom, $urandom, k == count - 1);
            end else begin
                lx = $urandom_range(0, 2000) - 1000;
                ty = $urandom_range(0, 2000) - 1000;
                send_box(lx, ty, lx - $urandom_range(17, 300), ty + $urandom_range(0, 300),
                         score, k == count - 1);
            end
        end
    endtask

    initial begin
        int set_no;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset settings. A box spanning the whole range; then two identical
        // boxes with tied scores (the later one is suppressed), a zero-area
        // box and a higher-scored disjoint box.
        send_box(-32768, -32768, 32767, 32767, 65535, 1'b1);
        send_box(100, 100, 400, 400, 100, 1'b0);
        send_box(100, 100, 400, 400, 100, 1'b0);
        send_box(500, 500, 300, 300, 0, 1'b0);
        send_box(2000, 2000, 2100, 2100, 65535, 1'b1);

        // Zero threshold and a keep limit of one: only the best box leaves.
        drain_and_configure(0, 1);
        send_box(0, 0, 160, 160, 500, 1'b0);
        send_box(10, 10, 170, 170, 900, 1'b0);
        send_box(-50, -50, 20, 20, 700, 1'b1);

        // Threshold at full scale suppresses nothing, even identical boxes.
        drain_and_configure(65536, 0);
        send_box(32767, 32767, -32768, -32768, 40, 1'b0);
        send_box(0, 0, 32, 32, 40, 1'b0);
        send_box(0, 0, 32, 32, 40, 1'b1);

        // Zero threshold, keep limit above the set size: two zero-area boxes
        // have a zero union and are never suppressed.
        drain_and_configure(0, 64);
        send_box(50, 50, 10, 10, 300, 1'b0);
        send_box(50, 50, 10, 10, 300, 1'b0);
        send_box(0, 0, 48, 48, 200, 1'b0);
        send_box(16, 16, 64, 64, 100, 1'b1);

        drain_and_configure(65535, 64);
        send_box(-32768, 32767, 32767, -32768, 0, 1'b1);

        // Random sets under changing settings. One set overflows the store.
        set_no = 0;
        while (boxes_sent < 370) begin
            if (set_no % 6 == 0) begin
                case ($urandom_range(0, 4))
                    0: drain_and_configure(29491, 0);
                    1: drain_and_configure($urandom_range(0, 65536), $urandom_range(0, 64));
                    2: drain_and_configure($urandom_range(10000, 50000), $urandom_range(1, 5));
                    3: drain_and_configure(65536, $urandom_range(0, 64));
                    default: drain_and_configure($urandom_range(0, 8000), 0);
                endcase
            end
            if (boxes_sent > 340) quiet = 1'b1;
            if (set_no == 5)
                send_random_set(70);
            else if ($urandom_range(0, 9) == 0)
                send_random_set($urandom_range(17, 40));
            else
                send_random_set($urandom_range(1, 16));
            set_no++;
        end

        i_in_valid <= 1'b0;
        repeat (2) @(posedge i_clk);
        while (owed_count != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && owed_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

FILE: box_non_maximum_suppression.f
src/bnms_pkg.sv
src/bnms_ram.sv
src/bnms_cmdq.sv
src/bnms_front.sv
src/bnms_back.sv
src/box_non_maximum_suppression.sv
bench/nms_checker.sv
bench/testbench.sv
